### rtl/core/fcorr_pkg.sv
// Shared types and constants for the streaming int16 correlation filter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package fcorr_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int ACC_W        = 32;
   localparam int IDX_W        = 16;
   localparam int SEEN_W       = 17;
   localparam int D_W          = SEEN_W + 1;
   localparam int WIN          = 16;
   localparam int WIN_W        = 4;
   localparam int OUT_MAX      = 16;
   localparam int CNT_W        = 5;
   localparam int TAPCNT_W     = 5;
   localparam int TAP_REGS     = 4;
   localparam int TAPS_PER_REG = 4;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_ADDR_W   = 6;

   localparam logic [SEEN_W-1:0]   SEEN_MAX      = '1;
   localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST = TAPCNT_W'(16);

   typedef enum logic [2:0] {
      REG_TAP_COUNT    = 3'd0,
      REG_TAPS_0_TO_3  = 3'd1,
      REG_TAPS_4_TO_7  = 3'd2,
      REG_TAPS_8_TO_11 = 3'd3,
      REG_TAPS_12_TO_15 = 3'd4,
      REG_OUTPUT_COUNT = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [TAPCNT_W-1:0]                  tap_count;
      logic [TAP_REGS-1:0][CSR_DATA_W-1:0]  taps;
      logic [IDX_W-1:0]                     output_count;
   } fcorr_cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0] out_index;
      logic             end_of_frame;
   } fcorr_meta_type;

endpackage

### rtl/core/fcorr_req_if.sv
// Input channel of the correlation filter: one sample item with its frame flag.
// Depends on fcorr_pkg for field widths.
`timescale 1ns / 1ps

interface fcorr_req_if import fcorr_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

### rtl/core/fcorr_rsp_if.sv
// Result channel of the correlation filter: one filtered value with its position.
// Depends on fcorr_pkg for field widths.
`timescale 1ns / 1ps

interface fcorr_rsp_if import fcorr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [ACC_W-1:0] filtered;
   logic [IDX_W-1:0]        out_index;
   logic                    end_of_frame;

   modport source (output valid, output filtered, output out_index, output end_of_frame,
                   input ready);
   modport sink   (input valid, input filtered, input out_index, input end_of_frame,
                   output ready);
endinterface

### rtl/core/fir_correlation_int16_top.sv
// Top level of the streaming int16 correlation filter: window, frame counters, issue.
// Depends on fcorr_pkg, fcorr_req_if, fcorr_rsp_if, fcorr_csr and fcorr_mac.
//
// Usage:
//   req_if carries one signed 16-bit sample per item plus last_sample, which marks the
//   end of a frame. rsp_if carries one filtered value per item with its out_index and
//   end_of_frame. Both are valid/ready channels; an item moves when both are high.
//   The APB-style port (psel..pready) holds tap_count, four 64-bit tap words and
//   output_count at byte addresses 0, 8, .. 40; write it only while the block is idle.
//   Once enough samples have arrived, each sample yields one result, up to output_count.
//   The last sample of a frame yields up to 16 results, one per cycle from the issue stage
//   unless it stalls; req_if.ready stays low for all but the last of them.
//   A result passes the issue, product, partial-sum and output registers after its sample
//   is accepted. Throughput: one sample and one result per cycle while rsp_if.ready is
//   high, set by the single issue register ahead of the product stage.
//   Reset clears the sample window, the frame counters, the pipeline and the registers
//   (tap_count 16, taps 0, output_count 0). When rsp_if.ready is low the pipeline fills
//   its empty stages and then holds; req_if.ready drops only once the issue stage waits.
`timescale 1ns / 1ps

module fir_correlation_int16_top import fcorr_pkg::*; #(
   parameter int MAX_TAPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   fcorr_req_if.sink             req_if,
   fcorr_rsp_if.source           rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   fcorr_cfg_type              cfg;
   logic signed [SAMPLE_W-1:0] window_ff [WIN];
   logic signed [SAMPLE_W-1:0] win_shift [WIN];
   logic [SEEN_W-1:0]          samples_seen_ff;
   logic [IDX_W-1:0]           outputs_done_ff;
   logic signed [SAMPLE_W-1:0] job_win_ff [WIN];
   logic [IDX_W-1:0]           job_k_ff;
   logic [D_W-1:0]             job_d_ff;
   logic [CNT_W-1:0]           job_cnt_ff;

   logic [TAPCNT_W-1:0]        taps_use;
   logic [SEEN_W-1:0]          seen_inc;
   logic [D_W-1:0]             need;
   logic                       first;
   logic [IDX_W-1:0]           od1;
   logic [IDX_W-1:0]           rem;
   logic [CNT_W-1:0]           cap;
   logic [CNT_W-1:0]           extra;
   logic [CNT_W-1:0]           total;
   logic                       accept;
   logic                       issue_valid;
   logic                       issue_ready;
   logic                       issue;

   logic signed [SAMPLE_W-1:0] lane_sample [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] lane_tap [MAX_TAPS];
   logic [MAX_TAPS-1:0]        lane_en;
   fcorr_meta_type             issue_meta;

   fcorr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   always_comb begin
      priority if (cfg.tap_count == '0) begin
         taps_use = TAPCNT_W'(1);
      end else if (cfg.tap_count > TAPCNT_W'(MAX_TAPS)) begin
         taps_use = TAPCNT_W'(MAX_TAPS);
      end else begin
         taps_use = cfg.tap_count;
      end
   end

   always_comb begin
      for (int i = 0; i < WIN - 1; i++) begin
         win_shift[i] = window_ff[i + 1];
      end
      win_shift[WIN-1] = req_if.sample;
   end

   always_comb begin
      seen_inc = (samples_seen_ff == SEEN_MAX) ? samples_seen_ff : samples_seen_ff + 1'b1;
      need     = D_W'(outputs_done_ff) + D_W'(taps_use);
      first    = (outputs_done_ff < cfg.output_count) && (need <= D_W'(seen_inc));
      od1      = outputs_done_ff + IDX_W'(first);
      rem      = cfg.output_count - od1;
      cap      = first ? CNT_W'(OUT_MAX - 1) : CNT_W'(OUT_MAX);
      if (od1 < cfg.output_count) begin
         extra = (rem < IDX_W'(cap)) ? CNT_W'(rem) : cap;
      end else begin
         extra = '0;
      end
      total = CNT_W'(first) + (req_if.last_sample ? extra : CNT_W'(0));
   end

   assign issue_valid  = job_cnt_ff != '0;
   assign issue        = issue_valid && issue_ready;
   assign req_if.ready = (job_cnt_ff == '0) || (job_cnt_ff == CNT_W'(1) && issue_ready);
   assign accept       = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff       <= '{default: '0};
         samples_seen_ff <= '0;
         outputs_done_ff <= '0;
         job_cnt_ff      <= '0;
      end else if (accept) begin
         job_cnt_ff <= total;
         if (req_if.last_sample) begin
            window_ff       <= '{default: '0};
            samples_seen_ff <= '0;
            outputs_done_ff <= '0;
         end else begin
            window_ff       <= win_shift;
            samples_seen_ff <= seen_inc;
            outputs_done_ff <= od1;
         end
      end else if (issue) begin
         job_cnt_ff <= job_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_win_ff <= win_shift;
         job_k_ff   <= outputs_done_ff;
         job_d_ff   <= D_W'(outputs_done_ff) - D_W'(seen_inc);
      end else if (issue) begin
         job_k_ff <= job_k_ff + 1'b1;
         job_d_ff <= job_d_ff + 1'b1;
      end
   end

   for (genvar m = 0; m < MAX_TAPS; m++) begin : g_lane
      localparam int RI = m / TAPS_PER_REG;
      localparam int BI = (m % TAPS_PER_REG) * SAMPLE_W;
      logic [D_W-1:0] e;

      assign e              = job_d_ff + D_W'(m);
      assign lane_sample[m] = job_win_ff[e[WIN_W-1:0]];
      assign lane_tap[m]    = cfg.taps[RI][BI +: SAMPLE_W];
      assign lane_en[m]     = (&e[D_W-1:WIN_W]) && (TAPCNT_W'(m) < taps_use);
   end

   assign issue_meta.out_index    = job_k_ff;
   assign issue_meta.end_of_frame = (cfg.output_count != '0)
                                    && (job_k_ff == cfg.output_count - 1'b1);

   fcorr_mac #(.LANES(MAX_TAPS)) u_mac (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue_ready (issue_ready),
      .lane_sample (lane_sample),
      .lane_tap    (lane_tap),
      .lane_en     (lane_en),
      .issue_meta  (issue_meta),
      .rsp_if      (rsp_if)
   );

`ifndef SYNTHESIS
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.last_sample) |=> (samples_seen_ff == '0 && outputs_done_ff == '0))
      else $error("frame counters not cleared after last item");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_if.last_sample) |=> (job_cnt_ff <= CNT_W'(1)))
      else $error("more than one result scheduled for a non-last item");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (issue && job_cnt_ff > CNT_W'(1)) |=> (job_k_ff == $past(job_k_ff) + 1'b1))
      else $error("output index did not advance on issue");
`endif

endmodule

### rtl/core/fcorr_csr.sv
// APB-style register file: tap count, four packed tap words, output count.
// Depends on fcorr_pkg.
`timescale 1ns / 1ps

module fcorr_csr import fcorr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output fcorr_cfg_type         cfg
);

   logic [TAPCNT_W-1:0]                 tap_count_ff;
   logic [TAP_REGS-1:0][CSR_DATA_W-1:0] taps_ff;
   logic [IDX_W-1:0]                    output_count_ff;
   logic                                wr_en;
   reg_idx_type                         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = reg_idx_type'(paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff    <= TAP_COUNT_RST;
         taps_ff         <= '0;
         output_count_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_TAP_COUNT:     tap_count_ff    <= pwdata[TAPCNT_W-1:0];
            REG_TAPS_0_TO_3:   taps_ff[0]      <= pwdata;
            REG_TAPS_4_TO_7:   taps_ff[1]      <= pwdata;
            REG_TAPS_8_TO_11:  taps_ff[2]      <= pwdata;
            REG_TAPS_12_TO_15: taps_ff[3]      <= pwdata;
            REG_OUTPUT_COUNT:  output_count_ff <= pwdata[IDX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TAP_COUNT:     prdata = CSR_DATA_W'(tap_count_ff);
         REG_TAPS_0_TO_3:   prdata = taps_ff[0];
         REG_TAPS_4_TO_7:   prdata = taps_ff[1];
         REG_TAPS_8_TO_11:  prdata = taps_ff[2];
         REG_TAPS_12_TO_15: prdata = taps_ff[3];
         REG_OUTPUT_COUNT:  prdata = CSR_DATA_W'(output_count_ff);
         default:           prdata = '0;
      endcase
   end

   assign cfg.tap_count    = tap_count_ff;
   assign cfg.taps         = taps_ff;
   assign cfg.output_count = output_count_ff;

endmodule

### rtl/core/fcorr_mac.sv
// Product and sum pipeline: lane products, grouped partial sums, output register.
// Depends on fcorr_pkg and fcorr_rsp_if.
`timescale 1ns / 1ps

module fcorr_mac import fcorr_pkg::*; #(
   parameter int LANES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       issue_valid,
   output logic                       issue_ready,
   input  logic signed [SAMPLE_W-1:0] lane_sample [LANES],
   input  logic signed [SAMPLE_W-1:0] lane_tap [LANES],
   input  logic [LANES-1:0]           lane_en,
   input  fcorr_meta_type             issue_meta,
   fcorr_rsp_if.source                rsp_if
);

   localparam int GRP  = 4;
   localparam int NGRP = (LANES + GRP - 1) / GRP;

   logic signed [ACC_W-1:0] mul [LANES];
   logic [ACC_W-1:0]        prod_in [LANES];
   logic [ACC_W-1:0]        prod_ff [LANES];
   logic [ACC_W-1:0]        part_in [NGRP];
   logic [ACC_W-1:0]        part_ff [NGRP];
   logic [ACC_W-1:0]        sum_in;
   logic [ACC_W-1:0]        out_sum_ff;
   fcorr_meta_type          p_meta_ff;
   fcorr_meta_type          s1_meta_ff;
   fcorr_meta_type          out_meta_ff;
   logic                    p_valid_ff;
   logic                    s1_valid_ff;
   logic                    out_valid_ff;
   logic                    out_load;
   logic                    s1_load;
   logic                    p_load;

   assign out_load    = !out_valid_ff || rsp_if.ready;
   assign s1_load     = !s1_valid_ff || out_load;
   assign p_load      = !p_valid_ff || s1_load;
   assign issue_ready = p_load;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         mul[l]     = lane_sample[l] * lane_tap[l];
         prod_in[l] = lane_en[l] ? mul[l] : '0;
      end
   end

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         part_in[g] = '0;
         for (int i = 0; i < GRP; i++) begin
            if (g * GRP + i < LANES) begin
               part_in[g] = part_in[g] + prod_ff[g * GRP + i];
            end
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < NGRP; g++) begin
         sum_in = sum_in + part_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (p_load) begin
            p_valid_ff <= issue_valid;
         end
         if (s1_load) begin
            s1_valid_ff <= p_valid_ff;
         end
         if (out_load) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_load && issue_valid) begin
         prod_ff   <= prod_in;
         p_meta_ff <= issue_meta;
      end
      if (s1_load && p_valid_ff) begin
         part_ff    <= part_in;
         s1_meta_ff <= p_meta_ff;
      end
      if (out_load && s1_valid_ff) begin
         out_sum_ff  <= sum_in;
         out_meta_ff <= s1_meta_ff;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.filtered     = out_sum_ff;
   assign rsp_if.out_index    = out_meta_ff.out_index;
   assign rsp_if.end_of_frame = out_meta_ff.end_of_frame;

endmodule
